// ----- rtl/hckm_pkg.sv -----
// Shared types, constants and register indexes for the HSV chroma key mask unit.
package hckm_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned HUE_W     = 9;
    localparam int unsigned SAT_W     = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 10;
    localparam int unsigned HN_W      = 17;
    localparam int unsigned SATP_W    = 18;

    localparam logic [HN_W-1:0]   DEG_60   = HN_W'(60);
    localparam logic [HN_W-1:0]   DEG_120  = HN_W'(120);
    localparam logic [HN_W-1:0]   DEG_240  = HN_W'(240);
    localparam logic [HN_W-1:0]   DEG_360  = HN_W'(360);
    localparam logic [SATP_W-1:0] PERMILLE = SATP_W'(1000);

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

    localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 9'd110;
    localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 9'd160;
    localparam logic [SAT_W-1:0] SAT_MIN_RESET  = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW  = 2'd0,
        REG_HUE_HIGH = 2'd1,
        REG_SAT_MIN  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_low;
        logic [HUE_W-1:0] hue_high;
        logic [SAT_W-1:0] sat_min_permille;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgba_t;

endpackage

// ----- rtl/hckm_cfg_regs.sv -----
// Configuration register file for the key limits.
module hckm_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hckm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [hckm_pkg::CFG_DAT_W-1:0]   cfg_data,
    output hckm_pkg::cfg_t                   cfg
);

    hckm_pkg::cfg_t cfg_reg;
    hckm_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_addr)
                hckm_pkg::REG_HUE_LOW:
                begin
                    cfg_next.hue_low = cfg_data[hckm_pkg::HUE_W-1:0];
                end
                hckm_pkg::REG_HUE_HIGH:
                begin
                    cfg_next.hue_high = cfg_data[hckm_pkg::HUE_W-1:0];
                end
                hckm_pkg::REG_SAT_MIN:
                begin
                    cfg_next.sat_min_permille = cfg_data[hckm_pkg::SAT_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low          <= hckm_pkg::HUE_LOW_RESET;
            cfg_reg.hue_high         <= hckm_pkg::HUE_HIGH_RESET;
            cfg_reg.sat_min_permille <= hckm_pkg::SAT_MIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/hckm_key_calc.sv -----
// Hue and saturation key decision for one pixel, combinational.
module hckm_key_calc
(
    input  hckm_pkg::rgb_t   pix,
    input  hckm_pkg::cfg_t   cfg,
    output hckm_pkg::rgba_t  res
);

    logic [hckm_pkg::CHAN_W-1:0] r;
    logic [hckm_pkg::CHAN_W-1:0] g;
    logic [hckm_pkg::CHAN_W-1:0] b;
    logic [hckm_pkg::CHAN_W-1:0] mx;
    logic [hckm_pkg::CHAN_W-1:0] mn;
    logic [hckm_pkg::CHAN_W-1:0] d;
    logic [hckm_pkg::HN_W-1:0]   d_w;
    logic [hckm_pkg::HN_W-1:0]   hn;
    logic [hckm_pkg::HN_W-1:0]   lo_prod;
    logic [hckm_pkg::HN_W-1:0]   hi_prod;
    logic [hckm_pkg::SATP_W-1:0] sat_lhs;
    logic [hckm_pkg::SATP_W-1:0] sat_rhs;
    logic                        hue_ok;
    logic                        sat_ok;
    logic                        keyed;

    assign r = pix.red;
    assign g = pix.green;
    assign b = pix.blue;

    always_comb
    begin
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
    end

    assign d   = mx - mn;
    assign d_w = hckm_pkg::HN_W'(d);

    always_comb
    begin
        if (r == mx)
        begin
            if (g >= b)
            begin
                hn = hckm_pkg::HN_W'(g - b) * hckm_pkg::DEG_60;
            end
            else
            begin
                hn = d_w * hckm_pkg::DEG_360 - hckm_pkg::HN_W'(b - g) * hckm_pkg::DEG_60;
            end
        end
        else if (g == mx)
        begin
            hn = d_w * hckm_pkg::DEG_120 + hckm_pkg::HN_W'(b) * hckm_pkg::DEG_60
                 - hckm_pkg::HN_W'(r) * hckm_pkg::DEG_60;
        end
        else
        begin
            hn = d_w * hckm_pkg::DEG_240 + hckm_pkg::HN_W'(r) * hckm_pkg::DEG_60
                 - hckm_pkg::HN_W'(g) * hckm_pkg::DEG_60;
        end
    end

    assign lo_prod = hckm_pkg::HN_W'(cfg.hue_low) * d_w;
    assign hi_prod = hckm_pkg::HN_W'(cfg.hue_high) * d_w;
    assign sat_lhs = hckm_pkg::PERMILLE * hckm_pkg::SATP_W'(d);
    assign sat_rhs = hckm_pkg::SATP_W'(cfg.sat_min_permille) * hckm_pkg::SATP_W'(mx);

    assign hue_ok = (hn >= lo_prod) && (hn <= hi_prod);
    assign sat_ok = (sat_lhs > sat_rhs);
    assign keyed  = (d != '0) && hue_ok && sat_ok;

    always_comb
    begin
        if (keyed)
        begin
            res.red   = '0;
            res.green = '0;
            res.blue  = '0;
            res.alpha = hckm_pkg::ALPHA_CLEAR;
        end
        else
        begin
            res.red   = r;
            res.green = g;
            res.blue  = b;
            res.alpha = hckm_pkg::ALPHA_OPAQUE;
        end
    end

endmodule

// ----- rtl/hsv_chroma_key_mask_unit.sv -----
// Top level of the HSV chroma key mask unit: input register, key logic, output register.
//
//  port group      dir   beat contents (low bit first)
//  s_axis_*        in    tdata = red_in, green_in, blue_in
//  m_axis_*        out   tdata = red_out, green_out, blue_out, alpha_out
//  cfg_*           in    cfg_addr = register index, cfg_data = value
//
//  Beats pass the input, then the output register; one pixel a cycle unless the output stalls.
//  The key decision is one pass of compare and multiply logic between the
//  input register and the output register.
//  Reset clears both stage valid flags and loads the limits 110, 160 and 100.
//  A stalled output holds its beat; the input register keeps taking beats while empty.
module hsv_chroma_key_mask_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // red_in, green_in, blue_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hckm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [hckm_pkg::CFG_DAT_W-1:0] cfg_data
);

    hckm_pkg::cfg_t  cfg;
    hckm_pkg::rgb_t  in_pix_reg;
    hckm_pkg::rgba_t calc_res;
    hckm_pkg::rgba_t out_pix_reg;
    logic            in_valid_reg;
    logic            in_valid_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;
    logic            in_load;
    logic            out_load;

    hckm_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hckm_key_calc u_key_calc
    (
        .pix (in_pix_reg),
        .cfg (cfg),
        .res (calc_res)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign out_load      = in_valid_reg && out_free;

    assign in_valid_next  = in_load || (in_valid_reg && !out_free);
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_pix_reg <= hckm_pkg::rgb_t'(s_axis_tdata);
        end
        if (out_load)
        begin
            out_pix_reg <= calc_res;
        end
    end

`ifndef SYNTH
    a_keyed_is_black : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_pix_reg.alpha == hckm_pkg::ALPHA_CLEAR))
        |-> (out_pix_reg.red == '0 && out_pix_reg.green == '0 && out_pix_reg.blue == '0))
        else $error("keyed pixel carries color");

    a_alpha_code : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_pix_reg.alpha == hckm_pkg::ALPHA_CLEAR
                           || out_pix_reg.alpha == hckm_pkg::ALPHA_OPAQUE))
        else $error("alpha neither clear nor opaque");

    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are blocked");

    a_accept_loads : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted beat lost at input register");

    a_cfg_hue_low : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_addr == hckm_pkg::REG_HUE_LOW)
        |=> (cfg.hue_low == $past(cfg_data[hckm_pkg::HUE_W-1:0])))
        else $error("hue_low write not taken");
`endif

endmodule
